// ===== src/loes_pkg.sv =====
// Shared types and constants for the layer-ordered entry sorter.
// No dependencies; loes_scan and the top level import this package.
`default_nettype none

package loes_pkg;

    // Sizing of the entry store and of the layer range that a draw visits.
    localparam int unsigned CAPACITY    = 64;
    localparam int unsigned LAYER_COUNT = 16;

    // Field widths.
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned LAYER_W  = 8;
    localparam int unsigned STATUS_W = 3;

    // Derived widths.
    localparam int unsigned ENTRY_W  = TAG_W + LAYER_W;
    localparam int unsigned DATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LV_W     = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

    // Command codes carried on the input side.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // One result word as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [LAYER_W-1:0]  layer;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

// ===== src/layer_ordered_entry_sorter_core.sv =====
// Top level of the layer-ordered entry sorter: stream ports and output register.
// Depends on loes_pkg, loes_scan and loes_ram.
//
// Usage: words on the s_ channel are commands. s_tuser carries the kind (add,
// draw, clear); for an add, s_tdata carries the entry tag and its layer. Every
// add or clear returns one word on the m_ channel with its status in m_tuser.
// A draw returns every stored entry whose layer is below LAYER_COUNT, lowest
// layer first and in arrival order within a layer, with m_tlast on the final
// word; a draw that finds nothing returns one word with the empty status.
// The unused kind is consumed and returns nothing.
//
// Timing: an add or clear passes through the done state back to idle, and its
// result is offered to the output register from the done state. A draw walks
// the store once per layer, with a RAM read state, then the shared layer compare
// state, for each stored entry and layer; the compare waits while a new hit
// finds the output register full. s_tready is low while a command is in
// progress.
//
// Reset empties the store (the entry count goes to zero) and the output
// register. When the receiver holds m_tready low, the scan pauses at the next
// entry to emit; no word is lost or repeated.
`default_nettype none

module layer_ordered_entry_sorter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // From bit 0: entry_tag (32), layer_key (8).
    input  logic [loes_pkg::DATA_W-1:0]   s_tdata,
    // kind (2).
    input  logic [loes_pkg::KIND_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0: out_tag (32), out_layer (8).
    output logic [loes_pkg::DATA_W-1:0]   m_tdata,
    // status (3).
    output logic [loes_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);

    import loes_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  m_tvalid_reg, m_tvalid_next;
    res_t  out_reg, out_next;

    loes_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_kind  (kind_t'(s_tuser)),
        .cmd_tag   (s_tdata[TAG_W-1:0]),
        .cmd_layer (s_tdata[ENTRY_W-1:TAG_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register takes a new word whenever it is empty or being drained.
    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res_ready ? res_valid : m_tvalid_reg;
    assign out_next      = (res_valid && res_ready) ? res : out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'({out_reg.layer, out_reg.tag});
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    // Only sorted entries carry a payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_ENTRY) |-> (m_tdata == '0))
        else $error("non-entry result carries payload");

    // Every status other than a sorted entry is a single-word reply.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_ENTRY) |-> m_tlast)
        else $error("single-word reply without tlast");

    // Entries at or above the layer count are never emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_ENTRY) |->
            (m_tdata[ENTRY_W-1:TAG_W] < LAYER_W'(LAYER_COUNT - 1) ||
             m_tdata[ENTRY_W-1:TAG_W] == LAYER_W'(LAYER_COUNT - 1)))
        else $error("emitted entry has out-of-range layer");

    // The sequencer never offers a result while it is taking a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !res_valid)
        else $error("result offered while idle");
`endif

endmodule

`default_nettype wire

// ===== src/loes_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module loes_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/loes_scan.sv =====
// Command sequencer of the sorter: entry store, add/clear handling and the
// layer-by-layer scan with its shared layer comparator. Uses loes_pkg and loes_ram.
`default_nettype none

module loes_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  loes_pkg::kind_t              cmd_kind,
    input  logic [loes_pkg::TAG_W-1:0]   cmd_tag,
    input  logic [loes_pkg::LAYER_W-1:0] cmd_layer,
    output logic                         res_valid,
    input  logic                         res_ready,
    output loes_pkg::res_t               res
);

    import loes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [LV_W-1:0]      lv_reg, lv_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [LAYER_W-1:0]   pend_layer_reg, pend_layer_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [TAG_W-1:0]     rd_tag;
    logic [LAYER_W-1:0]   rd_layer;
    logic                 hit;
    logic                 last_idx;
    logic                 last_lv;
    logic                 blocked;

    loes_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({cmd_layer, cmd_tag}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_tag   = ram_rdata[TAG_W-1:0];
    assign rd_layer = ram_rdata[ENTRY_W-1:TAG_W];

    // The one comparator that every step of the scan shares.
    assign hit      = (rd_layer == LAYER_W'(lv_reg));
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign last_lv  = (lv_reg == LV_W'(LAYER_COUNT - 1));
    // A new hit must push the held entry out first; wait if the output is full.
    assign blocked  = hit && pend_valid_reg && !res_ready;

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        lv_next         = lv_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_layer_next = pend_layer_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    pend_valid_next = 1'b0;
                    case (cmd_kind)
                        KIND_ADD: begin
                            if (count_reg < CNT_W'(CAPACITY)) begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_ADDED;
                            end else begin
                                status_next = ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                        KIND_CLEAR: begin
                            count_next  = '0;
                            status_next = ST_CLEARED;
                            state_next  = S_DONE;
                        end
                        KIND_DRAW: begin
                            // Reported only if the scan finds nothing.
                            status_next = ST_EMPTY;
                            idx_next    = '0;
                            lv_next     = '0;
                            state_next  = (count_reg == '0) ? S_DONE : S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (hit && pend_valid_reg) begin
                    res_valid    = 1'b1;
                    res.status   = ST_ENTRY;
                    res.tag      = pend_tag_reg;
                    res.layer    = pend_layer_reg;
                    res.last     = 1'b0;
                end
                if (!blocked) begin
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_tag_next   = rd_tag;
                        pend_layer_next = rd_layer;
                    end
                    if (last_idx) begin
                        idx_next = '0;
                        if (last_lv) begin
                            state_next = S_DONE;
                        end else begin
                            lv_next    = lv_reg + LV_W'(1);
                            state_next = S_READ;
                        end
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (pend_valid_reg) begin
                    res.status = ST_ENTRY;
                    res.tag    = pend_tag_reg;
                    res.layer  = pend_layer_reg;
                end else begin
                    res.status = status_reg;
                end
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        lv_reg         <= lv_next;
        pend_tag_reg   <= pend_tag_next;
        pend_layer_reg <= pend_layer_next;
        status_reg     <= status_next;
    end

endmodule

`default_nettype wire
